### hw/rtl/oli_pkg.sv
// Shared types, constants and helpers for the occluded light intensity block.
// Depends on nothing; every other file refers to it by scoped names.
package oli_pkg;

  // Vertex table geometry.
  localparam int unsigned MaxVertices = 256;
  localparam int unsigned AddrW       = $clog2(MaxVertices);
  localparam int unsigned CntW        = AddrW + 1;

  // Coordinate and register widths.
  localparam int unsigned CoordW  = 16;
  localparam int unsigned RadiusW = 14;
  localparam int unsigned DsqW    = 2 * RadiusW;      // distance squared after the reach check
  localparam int unsigned RootW   = (DsqW + 32) / 2;  // root of dsq * 2^32
  localparam int unsigned RootSteps = RootW;
  localparam int unsigned StepW   = $clog2(RootSteps);

  // Configuration register indexes.
  localparam logic [1:0] RegCenterX = 2'd0;
  localparam logic [1:0] RegCenterY = 2'd1;
  localparam logic [1:0] RegRadius  = 2'd2;

  localparam logic [RadiusW-1:0] RadiusReset = RadiusW'(100);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQR,
    ST_CHK,
    ST_WALK,
    ST_DRAIN,
    ST_ROOT,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RD_IDLE,
    RD_SQRT,
    RD_DIV,
    RD_FIN
  } rd_state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     mark;
  } vtx_t;

  // One edge beat handed to the geometry pipeline.
  typedef struct packed {
    logic                     valid;
    logic                     closing;
    logic                     poly_end;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
  } edge_t;

  // Sign-extend a coordinate by one bit so differences cannot overflow.
  function automatic logic signed [CoordW:0] sx(input logic signed [CoordW-1:0] v);
    sx = {v[CoordW-1], v};
  endfunction

endpackage

### hw/rtl/occluded_light_intensity.sv
// Top level of the occluded point-light intensity block: configuration registers,
// command control, vertex walk and result output. Depends on oli_pkg and all oli_ modules.
//
// Use: a command beat is taken when start_i is high and busy_o is low. Action clear
// empties the obstacle table and action append stores one vertex; both finish in the
// accepting cycle and leave busy_o low. Action query raises busy_o and, when done,
// presents intensity_o and vertices_dropped_o for one cycle with result_valid_o high.
// The receiver cannot stall; it must take the result in that cycle.
// Query sequence after the accepting edge: the reach check runs through states ST_DIFF,
// ST_SQR and ST_CHK, and when the point is beyond the radius (or the radius is zero) the
// result follows directly. Otherwise the table walk reads one vertex per cycle from the
// single read port of the vertex memory, the geometry pipeline drains, and the bit-serial
// square root and division run before the output state. An occluded point ends after the
// walk and skips the square root and division.
// A new command may be given in the cycle after result_valid_o.
// The APB port writes light center and radius; it should be used only while idle.
// Reset empties the table, clears the overflow flag and loads radius 100.
module occluded_light_intensity (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        action_i,
  input  logic signed [oli_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [oli_pkg::CoordW-1:0] coord_y_i,
  input  logic                              starts_polygon_i,
  output logic                              result_valid_o,
  output logic [15:0]                       intensity_o,
  output logic                              vertices_dropped_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  oli_pkg::ctrl_state_e state_q, state_d;

  logic signed [oli_pkg::CoordW-1:0]  cx_q, cy_q, px_q, py_q;
  logic [oli_pkg::RadiusW-1:0]        r_q;
  logic signed [oli_pkg::CoordW:0]    dx_q, dy_q;
  logic [2*oli_pkg::CoordW+1:0]       sqx_q, sqy_q;
  logic [oli_pkg::DsqW-1:0]           rsq_q, dsq_q;
  logic [2*oli_pkg::CoordW+2:0]       dsq;
  logic                               far;
  logic [15:0]                        res_q;

  logic                               accept, cfg_wr;
  logic                               st_clr, st_app;
  oli_pkg::vtx_t                      wr_vtx, rd_vtx;
  logic [oli_pkg::CntW-1:0]           vcount, issue_cnt_q;
  logic                               ovf;
  logic                               issue, rd_vld_q, rd_first_q, rd_last_q, tail_q;
  oli_pkg::vtx_t                      prev_q, first_q;
  oli_pkg::edge_t                     edge_q;
  logic                               pipe_busy, occl, walk_idle;
  logic                               rd_start, rd_done;
  logic [15:0]                        rd_int;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      r_q  <= oli_pkg::RadiusReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        oli_pkg::RegCenterX: cx_q <= pwdata[oli_pkg::CoordW-1:0];
        oli_pkg::RegCenterY: cy_q <= pwdata[oli_pkg::CoordW-1:0];
        oli_pkg::RegRadius:  r_q  <= pwdata[oli_pkg::RadiusW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      oli_pkg::RegCenterX: prdata = {16'b0, cx_q};
      oli_pkg::RegCenterY: prdata = {16'b0, cy_q};
      oli_pkg::RegRadius:  prdata = {18'b0, r_q};
      default:             prdata = '0;
    endcase
  end

  // Command decode.
  assign accept = start_i && !busy_o;
  assign st_clr = accept && (action_i == oli_pkg::ACT_CLEAR);
  assign st_app = accept && (action_i == oli_pkg::ACT_APPEND);
  assign wr_vtx = '{x: coord_x_i, y: coord_y_i, mark: starts_polygon_i};

  oli_vtx_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (st_clr),
    .app_i     (st_app),
    .wr_data_i (wr_vtx),
    .rd_en_i   (issue),
    .rd_addr_i (issue_cnt_q[oli_pkg::AddrW-1:0]),
    .rd_data_o (rd_vtx),
    .count_o   (vcount),
    .ovf_o     (ovf)
  );

  // Reach check arithmetic.
  assign dsq = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign far = (r_q == '0) || (dsq > {7'b0, rsq_q});

  assign issue     = (state_q == oli_pkg::ST_WALK) && (issue_cnt_q < vcount);
  assign walk_idle = !rd_vld_q && !tail_q && !pipe_busy;
  assign rd_start  = (state_q == oli_pkg::ST_DRAIN) && walk_idle && !occl;

  // Control state machine.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oli_pkg::ST_IDLE:  if (accept && action_i == oli_pkg::ACT_QUERY) state_d = oli_pkg::ST_DIFF;
      oli_pkg::ST_DIFF:  state_d = oli_pkg::ST_SQR;
      oli_pkg::ST_SQR:   state_d = oli_pkg::ST_CHK;
      oli_pkg::ST_CHK:   state_d = far ? oli_pkg::ST_OUT : oli_pkg::ST_WALK;
      oli_pkg::ST_WALK:  if (issue_cnt_q == vcount) state_d = oli_pkg::ST_DRAIN;
      oli_pkg::ST_DRAIN: if (walk_idle) state_d = occl ? oli_pkg::ST_OUT : oli_pkg::ST_ROOT;
      oli_pkg::ST_ROOT:  if (rd_done) state_d = oli_pkg::ST_OUT;
      oli_pkg::ST_OUT:   state_d = oli_pkg::ST_IDLE;
      default:           state_d = oli_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oli_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Query datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
    dx_q  <= oli_pkg::sx(px_q) - oli_pkg::sx(cx_q);
    dy_q  <= oli_pkg::sx(py_q) - oli_pkg::sx(cy_q);
    sqx_q <= (2*oli_pkg::CoordW+2)'(dx_q * dx_q);
    sqy_q <= (2*oli_pkg::CoordW+2)'(dy_q * dy_q);
    rsq_q <= oli_pkg::DsqW'(r_q * r_q);
    if (state_q == oli_pkg::ST_CHK) begin
      dsq_q <= dsq[oli_pkg::DsqW-1:0];
      if (far) res_q <= '0;
    end
    if (state_q == oli_pkg::ST_DRAIN && walk_idle && occl) res_q <= '0;
    if (state_q == oli_pkg::ST_ROOT && rd_done) res_q <= rd_int;
  end

  // Walk counter and read tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_cnt_q <= '0;
      rd_vld_q    <= 1'b0;
      rd_first_q  <= 1'b0;
      rd_last_q   <= 1'b0;
      tail_q      <= 1'b0;
      edge_q      <= '0;
    end else begin
      if (state_q == oli_pkg::ST_CHK) begin
        issue_cnt_q <= '0;
      end else if (issue) begin
        issue_cnt_q <= issue_cnt_q + 1'b1;
      end
      rd_vld_q   <= issue;
      rd_first_q <= (issue_cnt_q == '0);
      rd_last_q  <= ((issue_cnt_q + 1'b1) == vcount);
      tail_q     <= rd_vld_q && rd_last_q;
      // Edge beats: consecutive edges, and closing edges at each polygon end.
      if (rd_vld_q && !rd_first_q) begin
        edge_q.valid    <= 1'b1;
        edge_q.closing  <= rd_vtx.mark;
        edge_q.poly_end <= rd_vtx.mark;
        edge_q.ax       <= prev_q.x;
        edge_q.ay       <= prev_q.y;
        edge_q.bx       <= rd_vtx.mark ? first_q.x : rd_vtx.x;
        edge_q.by       <= rd_vtx.mark ? first_q.y : rd_vtx.y;
      end else if (tail_q) begin
        edge_q.valid    <= 1'b1;
        edge_q.closing  <= 1'b1;
        edge_q.poly_end <= 1'b1;
        edge_q.ax       <= prev_q.x;
        edge_q.ay       <= prev_q.y;
        edge_q.bx       <= first_q.x;
        edge_q.by       <= first_q.y;
      end else begin
        edge_q.valid    <= 1'b0;
      end
    end
  end

  // Previous vertex and current polygon start.
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prev_q <= rd_vtx;
      if (rd_first_q || rd_vtx.mark) first_q <= rd_vtx;
    end
  end

  oli_edge_pipe u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (state_q == oli_pkg::ST_CHK),
    .edge_i (edge_q),
    .cx_i   (cx_q),
    .cy_i   (cy_q),
    .px_i   (px_q),
    .py_i   (py_q),
    .busy_o (pipe_busy),
    .occl_o (occl)
  );

  oli_root_div u_root (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (rd_start),
    .dsq_i       (dsq_q),
    .radius_i    (r_q),
    .done_o      (rd_done),
    .intensity_o (rd_int)
  );

  // Outputs.
  assign busy_o             = (state_q != oli_pkg::ST_IDLE);
  assign result_valid_o     = (state_q == oli_pkg::ST_OUT);
  assign intensity_o        = res_q;
  assign vertices_dropped_o = ovf;

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result beat longer than one cycle");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == oli_pkg::ACT_QUERY) |=> busy_o && !result_valid_o)
    else $error("query accepted without going busy");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (issue_cnt_q < vcount) && !st_app && !st_clr)
    else $error("vertex read beyond fill count or during table update");

  a_root_only_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_start |-> !occl && !pipe_busy)
    else $error("root unit started before walk finished");

endmodule

### hw/rtl/oli_vtx_store.sv
// Vertex table: synchronous memory of obstacle vertices with fill count and overflow flag.
// Depends on oli_pkg.
module oli_vtx_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clr_i,
  input  logic                      app_i,
  input  oli_pkg::vtx_t             wr_data_i,
  input  logic                      rd_en_i,
  input  logic [oli_pkg::AddrW-1:0] rd_addr_i,
  output oli_pkg::vtx_t             rd_data_o,
  output logic [oli_pkg::CntW-1:0]  count_o,
  output logic                      ovf_o
);

  oli_pkg::vtx_t                mem [oli_pkg::MaxVertices];
  logic [oli_pkg::CntW-1:0]     count_q;
  logic                         ovf_q;
  logic                         full;
  oli_pkg::vtx_t                rd_data_q;

  assign full = (count_q == oli_pkg::CntW'(oli_pkg::MaxVertices));

  // Fill count and overflow flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (clr_i) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (app_i) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // Memory write at the fill point and registered read.
  always_ff @(posedge clk_i) begin
    if (app_i && !clr_i && !full) begin
      mem[count_q[oli_pkg::AddrW-1:0]] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign count_o   = count_q;
  assign ovf_o     = ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= oli_pkg::CntW'(oli_pkg::MaxVertices))
    else $error("vertex count beyond table size");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_i |=> (count_q == '0) && !ovf_q)
    else $error("clear did not empty the table");

  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (app_i && !clr_i && full) |=> ovf_q && full)
    else $error("append on a full table not flagged");

endmodule

### hw/rtl/oli_edge_pipe.sv
// Geometry pipeline: per edge beat, even-odd ray crossings for center and point and
// the segment hit test, accumulated into one occlusion flag. Depends on oli_pkg.
module oli_edge_pipe (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              clr_i,
  input  oli_pkg::edge_t                    edge_i,
  input  logic signed [oli_pkg::CoordW-1:0] cx_i,
  input  logic signed [oli_pkg::CoordW-1:0] cy_i,
  input  logic signed [oli_pkg::CoordW-1:0] px_i,
  input  logic signed [oli_pkg::CoordW-1:0] py_i,
  output logic                              busy_o,
  output logic                              occl_o
);

  localparam int unsigned DW = oli_pkg::CoordW + 1;
  localparam int unsigned PW = 2 * DW;

  // Stage 1: differences.
  logic                 v1_q, cl1_q, end1_q, hz1_q, inc1_q, inp1_q;
  logic signed [DW-1:0] ex_q, ey_q, cx1_q, cy1_q, px1_q, py1_q;
  logic signed [DW-1:0] d1x_q, d1y_q, d2x_q, d2y_q, wx_q, wy_q;
  // Stage 2: products.
  logic                 v2_q, cl2_q, end2_q, hz2_q, inc2_q, inp2_q;
  logic signed [PW-1:0] rcl_q, rcr_q, rpl_q, rpr_q;
  logic signed [PW-1:0] den1_q, den2_q, tn1_q, tn2_q, un1_q, un2_q;
  // Stage 3: decisions.
  logic                 v3_q, end3_q, crc3_q, crp3_q, hit3_q;
  // Accumulators.
  logic                 pc_q, pp_q, occl_q;

  logic signed [oli_pkg::CoordW-1:0] x1, y1, x2, y2;
  logic signed [PW+1:0]              den, tn, un;
  logic                              crc, crp, hit, pc_n, pp_n;

  // Order the edge by y for the ray test.
  always_comb begin
    if (edge_i.by < edge_i.ay) begin
      x1 = edge_i.bx; y1 = edge_i.by; x2 = edge_i.ax; y2 = edge_i.ay;
    end else begin
      x1 = edge_i.ax; y1 = edge_i.ay; x2 = edge_i.bx; y2 = edge_i.by;
    end
  end

  always_ff @(posedge clk_i) begin
    ex_q  <= oli_pkg::sx(x2) - oli_pkg::sx(x1);
    ey_q  <= oli_pkg::sx(y2) - oli_pkg::sx(y1);
    cx1_q <= oli_pkg::sx(cx_i) - oli_pkg::sx(x1);
    cy1_q <= oli_pkg::sx(cy_i) - oli_pkg::sx(y1);
    px1_q <= oli_pkg::sx(px_i) - oli_pkg::sx(x1);
    py1_q <= oli_pkg::sx(py_i) - oli_pkg::sx(y1);
    d1x_q <= oli_pkg::sx(px_i) - oli_pkg::sx(cx_i);
    d1y_q <= oli_pkg::sx(py_i) - oli_pkg::sx(cy_i);
    d2x_q <= oli_pkg::sx(edge_i.bx) - oli_pkg::sx(edge_i.ax);
    d2y_q <= oli_pkg::sx(edge_i.by) - oli_pkg::sx(edge_i.ay);
    wx_q  <= oli_pkg::sx(edge_i.ax) - oli_pkg::sx(cx_i);
    wy_q  <= oli_pkg::sx(edge_i.ay) - oli_pkg::sx(cy_i);
    cl1_q  <= edge_i.closing;
    end1_q <= edge_i.poly_end;
    hz1_q  <= (edge_i.ay == edge_i.by);
    inc1_q <= (cy_i >= y1) && (cy_i < y2);
    inp1_q <= (py_i >= y1) && (py_i < y2);

    // One multiplier per product, each registered.
    rcl_q  <= PW'(ex_q * cy1_q);
    rcr_q  <= PW'(cx1_q * ey_q);
    rpl_q  <= PW'(ex_q * py1_q);
    rpr_q  <= PW'(px1_q * ey_q);
    den1_q <= PW'(d1x_q * d2y_q);
    den2_q <= PW'(d1y_q * d2x_q);
    tn1_q  <= PW'(wx_q * d2y_q);
    tn2_q  <= PW'(wy_q * d2x_q);
    un1_q  <= PW'(wx_q * d1y_q);
    un2_q  <= PW'(wy_q * d1x_q);
    cl2_q  <= cl1_q;
    end2_q <= end1_q;
    hz2_q  <= hz1_q;
    inc2_q <= inc1_q;
    inp2_q <= inp1_q;

    end3_q <= end2_q;
    crc3_q <= crc;
    crp3_q <= crp;
    hit3_q <= hit;
  end

  // Crossing and hit decisions from the products.
  always_comb begin
    crc = !hz2_q && inc2_q && (rcl_q <= rcr_q);
    crp = !hz2_q && inp2_q && (rpl_q <= rpr_q);
    den = (PW+2)'(den1_q - den2_q);
    tn  = (PW+2)'(tn1_q - tn2_q);
    un  = (PW+2)'(un1_q - un2_q);
    if (den < 0) begin
      den = -den;
      tn  = -tn;
      un  = -un;
    end
    hit = !cl2_q && (den != 0) && (tn >= 0) && (tn <= den) && (un >= 0) && (un <= den);
  end

  assign pc_n = pc_q ^ crc3_q;
  assign pp_n = pp_q ^ crp3_q;

  // Valid bits and the parity and occlusion accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      pc_q   <= 1'b0;
      pp_q   <= 1'b0;
      occl_q <= 1'b0;
    end else begin
      v1_q <= edge_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (clr_i) begin
        pc_q   <= 1'b0;
        pp_q   <= 1'b0;
        occl_q <= 1'b0;
      end else if (v3_q) begin
        if (end3_q) begin
          pc_q <= 1'b0;
          pp_q <= 1'b0;
          occl_q <= occl_q | hit3_q | pc_n | pp_n;
        end else begin
          pc_q <= pc_n;
          pp_q <= pp_n;
          occl_q <= occl_q | hit3_q;
        end
      end
    end
  end

  assign busy_o = edge_i.valid | v1_q | v2_q | v3_q;
  assign occl_o = occl_q;

endmodule

### hw/rtl/oli_root_div.sv
// Intensity unit: bit-serial square root of dsq*2^32, then restoring division by the
// radius and the final rounding and saturation. Depends on oli_pkg.
module oli_root_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [oli_pkg::DsqW-1:0]           dsq_i,
  input  logic [oli_pkg::RadiusW-1:0]        radius_i,
  output logic                               done_o,
  output logic [15:0]                        intensity_o
);

  localparam int unsigned RW = oli_pkg::RootW;

  oli_pkg::rd_state_e            state_q, state_d;
  logic [oli_pkg::StepW-1:0]     step_q;
  logic [oli_pkg::DsqW-1:0]      rad_q;
  logic [RW+1:0]                 rem_q;
  logic [RW-1:0]                 root_q;
  logic [oli_pkg::RadiusW-1:0]   drem_q;
  logic                          exact_q;

  logic [RW+3:0]                 sq_work, sq_trial;
  logic                          sq_ge;
  logic [oli_pkg::RadiusW:0]     dv_work;
  logic                          dv_ge;
  logic [RW:0]                   k_full;
  logic [16:0]                   k_sat, v_full;
  logic                          last;

  assign last = (step_q == '0);

  // Step logic for both phases.
  always_comb begin
    sq_work  = {rem_q, rad_q[oli_pkg::DsqW-1 -: 2]};
    sq_trial = {2'b00, root_q, 2'b01};
    sq_ge    = (sq_work >= sq_trial);
    dv_work  = {drem_q, root_q[RW-1]};
    dv_ge    = (dv_work >= {1'b0, radius_i});
    if (exact_q) begin
      k_full = {1'b0, root_q} + (RW+1)'(drem_q != '0);
    end else begin
      k_full = {1'b0, root_q} + 1'b1;
    end
    k_sat  = (k_full > (RW+1)'(65536)) ? 17'd65536 : k_full[16:0];
    v_full = 17'd65536 - k_sat;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oli_pkg::RD_IDLE: if (start_i) state_d = oli_pkg::RD_SQRT;
      oli_pkg::RD_SQRT: if (last) state_d = oli_pkg::RD_DIV;
      oli_pkg::RD_DIV:  if (last) state_d = oli_pkg::RD_FIN;
      oli_pkg::RD_FIN:  state_d = oli_pkg::RD_IDLE;
      default:          state_d = oli_pkg::RD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oli_pkg::RD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      oli_pkg::RD_IDLE: begin
        step_q <= oli_pkg::StepW'(oli_pkg::RootSteps - 1);
        rad_q  <= dsq_i;
        rem_q  <= '0;
        root_q <= '0;
        drem_q <= '0;
      end
      oli_pkg::RD_SQRT: begin
        rad_q  <= {rad_q[oli_pkg::DsqW-3:0], 2'b00};
        rem_q  <= sq_ge ? (RW+2)'(sq_work - sq_trial) : (RW+2)'(sq_work);
        root_q <= {root_q[RW-2:0], sq_ge};
        step_q <= last ? oli_pkg::StepW'(oli_pkg::RootSteps - 1) : step_q - 1'b1;
        if (last) begin
          exact_q <= sq_ge ? ((sq_work - sq_trial) == '0) : (sq_work == '0);
        end
      end
      oli_pkg::RD_DIV: begin
        drem_q <= dv_ge ? oli_pkg::RadiusW'(dv_work - {1'b0, radius_i})
                        : dv_work[oli_pkg::RadiusW-1:0];
        root_q <= {root_q[RW-2:0], dv_ge};
        step_q <= step_q - 1'b1;
      end
      default: begin
        intensity_o <= v_full[16] ? 16'hFFFF : v_full[15:0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= (state_q == oli_pkg::RD_FIN);
    end
  end

endmodule
